// ===== src/ptmt_pkg.sv =====
package ptmt_pkg;

    // One pending timestamp record as held by a table cell.
    typedef struct packed {
        logic [3:0]  typ;
        logic [3:0]  port;
        logic [15:0] seq;
        logic [63:0] corr;
    } t_rec;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_DONE
    } t_state;

    localparam logic       REQ_LOOKUP = 1'b0;
    localparam logic       REQ_APPEND = 1'b1;

    localparam logic [15:0] ENCRYPTED_FLAG = 16'h0080;

    localparam logic [2:0] ST_MATCH         = 3'd0;
    localparam logic [2:0] ST_NOMATCH       = 3'd1;
    localparam logic [2:0] ST_SKIPPED       = 3'd2;
    localparam logic [2:0] ST_APPENDED      = 3'd3;
    localparam logic [2:0] ST_APPENDED_DROP = 3'd4;

endpackage

// ===== src/ptmt_cell.sv =====
module ptmt_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  ptmt_pkg::t_rec i_rec,
    output ptmt_pkg::t_rec o_rec
);
    import ptmt_pkg::*;

    t_rec r_rec;

    // The cell takes its younger neighbor's record on every shift step.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

// ===== src/ptp_timestamp_match_table_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------------
// request  | in        | i_in_valid / o_in_ready    | req_type, msg_type, port_id,
//          |           |                            | sequence_id, flag_field, entry_corr.
// result   | out       | o_out_valid / i_out_ready  | status, correction, fill_level
//
// An append or an encrypted lookup rotates the record chain once through all TABLE_DEPTH
// cells, one step a cycle, before the finishing step loads the result.
// A lookup without the encrypted flag skips the rotation and goes to the finishing step.
// Reset clears the fill count and the control state; record contents are not reset.
// A new request is taken as soon as the previous result sits in the output register;
// a stalled output holds the finishing step until that register is free.
module ptp_timestamp_match_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [3:0]  i_msg_type,
    input  logic [7:0]  i_port_id,
    input  logic [15:0] i_sequence_id,
    input  logic [15:0] i_flag_field,
    input  logic [63:0] i_entry_correction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_correction,
    output logic [6:0]  o_fill_level
);
    import ptmt_pkg::*;

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_VAL = FILL_W'(TABLE_DEPTH);
    localparam logic [FILL_W-1:0] LAST_STEP = FILL_W'(TABLE_DEPTH - 1);

    t_state r_state, n_state;

    t_rec              r_key;
    logic              r_append;
    logic              r_enc;
    logic              r_full;
    logic              r_found;
    logic [63:0]       r_hit_corr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_cnt;

    logic              r_out_valid;
    logic [2:0]        r_status, n_status;
    logic [63:0]       r_corr_out;
    logic [6:0]        r_fill_out;

    t_rec              w_chain [TABLE_DEPTH];
    t_rec              w_tail;
    logic              w_shift;
    logic              w_accept;
    logic              w_load_out;
    logic              w_out_free;
    logic              w_in_enc;
    logic              w_in_range;
    logic              w_match_now;
    logic              w_skip;
    logic              w_push_new;
    logic [FILL_W-1:0] w_new_pos;
    logic [FILL_W+6:0] w_fill_ext;

    // Record chain: cell 0 holds the oldest record, the tail cell takes the pushed record.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_tail
            ptmt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_rec   (w_tail),
                .o_rec   (w_chain[g])
            );
        end else begin : g_body
            ptmt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_rec   (w_chain[g+1]),
                .o_rec   (w_chain[g])
            );
        end
    end

    assign w_in_enc   = (i_flag_field & ENCRYPTED_FLAG) != 16'd0;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // At step k of a pass, cell 0 holds record k. Pushing cell 1 instead of cell 0
    // from some step on removes one record; the pushed sequence becomes the new table.
    assign w_in_range  = r_cnt < r_fill;
    assign w_match_now = !r_append && !r_found && w_in_range
                         && (w_chain[0].typ == r_key.typ)
                         && (w_chain[0].port == r_key.port)
                         && (w_chain[0].seq == r_key.seq);
    assign w_skip      = (r_append && r_full) || r_found || w_match_now;
    assign w_new_pos   = r_full ? LAST_STEP : r_fill;
    assign w_push_new  = r_append && (r_cnt == w_new_pos);

    always_comb begin
        if (w_push_new) begin
            w_tail = r_key;
        end else if (w_skip) begin
            w_tail = w_chain[1];
        end else begin
            w_tail = w_chain[0];
        end
    end

    always_comb begin
        n_state    = r_state;
        w_shift    = 1'b0;
        w_accept   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    if (i_req_type == REQ_APPEND || w_in_enc) begin
                        n_state = S_PASS;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PASS: begin
                w_shift = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (r_append) begin
            n_status = r_full ? ST_APPENDED_DROP : ST_APPENDED;
            if (!r_full) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end else if (!r_enc) begin
            n_status = ST_SKIPPED;
        end else if (r_found) begin
            n_status = ST_MATCH;
            n_fill   = r_fill - FILL_W'(1);
        end else begin
            n_status = ST_NOMATCH;
        end
    end

    assign w_fill_ext = {7'd0, n_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (w_shift) begin
                r_cnt <= r_cnt + FILL_W'(1);
                if (w_match_now) begin
                    r_found <= 1'b1;
                end
            end
            if (w_load_out) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.typ  <= i_msg_type;
            r_key.port <= i_port_id[3:0];
            r_key.seq  <= i_sequence_id;
            r_key.corr <= i_entry_correction;
            r_append   <= (i_req_type == REQ_APPEND);
            r_enc      <= w_in_enc;
            r_full     <= (r_fill == DEPTH_VAL);
        end
        if (w_shift && w_match_now) begin
            r_hit_corr <= w_chain[0].corr;
        end
        if (w_load_out) begin
            r_status   <= n_status;
            r_corr_out <= (n_status == ST_MATCH) ? r_hit_corr : 64'd0;
            r_fill_out <= w_fill_ext[6:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_correction = r_corr_out;
    assign o_fill_level = r_fill_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_VAL)
        else $error("fill count above table depth");

    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS && r_cnt != LAST_STEP) |=> (r_cnt == $past(r_cnt) + FILL_W'(1)))
        else $error("pass step counter did not advance");

    a_match_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && n_status == ST_MATCH) |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("matched lookup did not remove a record");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && n_status == ST_APPENDED_DROP) |=> (r_fill == DEPTH_VAL))
        else $error("append with drop left table not full");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && w_match_now) |-> (r_fill != '0 && !r_append))
        else $error("match taken outside held records");

endmodule

// ===== tb/sv/tb_ptp_timestamp_match_table_core.sv =====
module tb_ptp_timestamp_match_table_core;
    import ptmt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int STALL_CYCLES = 400;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        logic        req;
        logic [3:0]  typ;
        logic [7:0]  port;
        logic [15:0] seq;
        logic [15:0] flags;
        logic [63:0] corr;
    } t_req_item;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] corr;
        logic [6:0]  fill;
    } t_res_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = REQ_LOOKUP;
    logic [3:0]  i_msg_type = '0;
    logic [7:0]  i_port_id = '0;
    logic [15:0] i_sequence_id = '0;
    logic [15:0] i_flag_field = '0;
    logic [63:0] i_entry_correction = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [63:0] o_correction;
    logic [6:0]  o_fill_level;

    // Shadow copy of the record table, oldest record at index 0.
    t_rec      shadow_tbl[$];
    t_res_item pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_gen = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int mismatches = 0;

    ptp_timestamp_match_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_msg_type         (i_msg_type),
        .i_port_id          (i_port_id),
        .i_sequence_id      (i_sequence_id),
        .i_flag_field       (i_flag_field),
        .i_entry_correction (i_entry_correction),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_correction       (o_correction),
        .o_fill_level       (o_fill_level)
    );

    always #4 i_clk = ~i_clk;

    // Applies one request to the shadow table and returns the result it should produce.
    function automatic t_res_item table_apply(t_req_item r);
        t_res_item o;
        t_rec      nr;
        int        hit;
        o.corr = '0;
        hit = -1;
        if (r.req == REQ_APPEND) begin
            o.status = ST_APPENDED;
            if (shadow_tbl.size() >= DEPTH) begin
                void'(shadow_tbl.pop_front());
                o.status = ST_APPENDED_DROP;
            end
            nr.typ  = r.typ;
            nr.port = r.port[3:0];
            nr.seq  = r.seq;
            nr.corr = r.corr;
            shadow_tbl.push_back(nr);
        end else if ((r.flags & ENCRYPTED_FLAG) == 16'h0000) begin
            o.status = ST_SKIPPED;
        end else begin
            o.status = ST_NOMATCH;
            foreach (shadow_tbl[i]) begin
                if (hit < 0 && shadow_tbl[i].typ == r.typ && shadow_tbl[i].port == r.port[3:0]
                        && shadow_tbl[i].seq == r.seq) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                o.corr = shadow_tbl[hit].corr;
                shadow_tbl.delete(hit);
                o.status = ST_MATCH;
            end
        end
        o.fill = 7'(shadow_tbl.size());
        return o;
    endfunction

    function automatic t_req_item make_req(logic req, logic [3:0] typ, logic [7:0] port,
                                           logic [15:0] seq, logic [15:0] flags,
                                           logic [63:0] corr);
        t_req_item r;
        r.req   = req;
        r.typ   = typ;
        r.port  = port;
        r.seq   = seq;
        r.flags = flags;
        r.corr  = corr;
        return r;
    endfunction

    // Random request. A quarter of the keys come from a tiny pool so that duplicates occur,
    // and most lookups reuse the key of a record that is currently held.
    function automatic t_req_item next_request();
        t_req_item r;
        int        pick;
        int        idx;
        bit        narrow;
        pick   = $urandom_range(0, 99);
        narrow = ($urandom_range(0, 3) == 0);
        r.req   = (pick < 45) ? REQ_APPEND : REQ_LOOKUP;
        r.typ   = narrow ? 4'($urandom_range(0, 3)) : 4'($urandom);
        r.port  = narrow ? {4'($urandom), 4'($urandom_range(0, 3))} : 8'($urandom);
        r.seq   = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        r.flags = 16'($urandom) | ENCRYPTED_FLAG;
        r.corr  = {$urandom, $urandom};
        if (((pick >= 45 && pick < 75) || pick >= 88) && shadow_tbl.size() > 0) begin
            idx = $urandom_range(0, shadow_tbl.size() - 1);
            r.typ       = shadow_tbl[idx].typ;
            r.port[3:0] = shadow_tbl[idx].port;
            r.seq       = shadow_tbl[idx].seq;
        end
        if (pick >= 88) begin
            r.flags = r.flags & ~ENCRYPTED_FLAG;
        end
        return r;
    endfunction

    // Entered and left just after a rising edge; valid is lowered only when a gap is taken.
    task automatic send_request(t_req_item r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_req_type         <= r.req;
        i_msg_type         <= r.typ;
        i_port_id          <= r.port;
        i_sequence_id      <= r.seq;
        i_flag_field       <= r.flags;
        i_entry_correction <= r.corr;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(table_apply(r));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic test_directed();
        set_idling(36, 68);
        send_request(make_req(REQ_LOOKUP, 4'h0, 8'h00, 16'h0000, ENCRYPTED_FLAG, '0));
        send_request(make_req(REQ_LOOKUP, 4'hf, 8'hff, 16'hffff, 16'hff7f, '1));
        send_request(make_req(REQ_APPEND, 4'h0, 8'h00, 16'h0000, 16'h0000, '0));
        send_request(make_req(REQ_APPEND, 4'hf, 8'hff, 16'hffff, 16'hffff, '1));
        send_request(make_req(REQ_APPEND, 4'h0, 8'hf0, 16'h0000, 16'h0080,
                              64'h8000_0000_0000_0001));
        send_request(make_req(REQ_APPEND, 4'h5, 8'h3a, 16'h1234, 16'h0000,
                              64'h0123_4567_89ab_cdef));
        // Skipped lookup that would otherwise match.
        send_request(make_req(REQ_LOOKUP, 4'hf, 8'h0f, 16'hffff, 16'hff7f, '0));
        // Port high nibble differs from the stored one and must be ignored.
        send_request(make_req(REQ_LOOKUP, 4'hf, 8'h0f, 16'hffff, ENCRYPTED_FLAG, '1));
        // Near misses on each key field.
        send_request(make_req(REQ_LOOKUP, 4'h4, 8'h3a, 16'h1234, 16'hffff, '0));
        send_request(make_req(REQ_LOOKUP, 4'h5, 8'h3b, 16'h1234, 16'hffff, '0));
        send_request(make_req(REQ_LOOKUP, 4'h5, 8'h3a, 16'h1235, 16'hffff, '0));
        // Two records share this key; the older one goes first.
        send_request(make_req(REQ_LOOKUP, 4'h0, 8'ha0, 16'h0000, 16'h0080, '1));
        send_request(make_req(REQ_LOOKUP, 4'h0, 8'h50, 16'h0000, 16'hffff, '0));
        send_request(make_req(REQ_LOOKUP, 4'h0, 8'h00, 16'h0000, 16'h0080, '0));
        send_request(make_req(REQ_LOOKUP, 4'h5, 8'hca, 16'h1234, 16'h00ff, '0));
        send_request(make_req(REQ_LOOKUP, 4'h5, 8'hca, 16'h1234, 16'h00ff, '0));
        wait_drained();
    endtask

    task automatic test_fill_and_drop();
        t_req_item r;
        t_req_item first;
        int        idx;
        set_idling(36, 68);
        first = next_request();
        first.req = REQ_APPEND;
        send_request(first);
        for (int k = 1; k < DEPTH + 6; k++) begin
            r = next_request();
            r.req = REQ_APPEND;
            send_request(r);
        end
        // The first record has been pushed out by now.
        first.req   = REQ_LOOKUP;
        first.flags = first.flags | ENCRYPTED_FLAG;
        send_request(first);
        while (shadow_tbl.size() > 0) begin
            r = next_request();
            idx = $urandom_range(0, shadow_tbl.size() - 1);
            r.req       = REQ_LOOKUP;
            r.typ       = shadow_tbl[idx].typ;
            r.port[3:0] = shadow_tbl[idx].port;
            r.seq       = shadow_tbl[idx].seq;
            r.flags     = r.flags | ENCRYPTED_FLAG;
            send_request(r);
        end
        wait_drained();
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        set_idling(send_pct, recv_pct);
        repeat (count) send_request(next_request());
        wait_drained();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        set_idling(0, 0);
        stall_gen <= stall_gen + 1;
        repeat (40) send_request(next_request());
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (stall_seen != stall_gen) begin
            stall_seen  <= stall_gen;
            stall_left  <= STALL_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d fill %0d", o_status, o_fill_level);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_correction !== want.corr) begin
                    $error("correction: expected %h, actual %h", want.corr, o_correction);
                    mismatches++;
                end
                if (o_fill_level !== want.fill) begin
                    $error("fill_level: expected %0d, actual %0d", want.fill, o_fill_level);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_and_drop();
        test_random(300, 36, 68);
        test_random(300, 68, 36);
        test_random(300, 0, 0);
        test_backpressure();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 8);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
